>>> sv/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the strip energy blocks.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off while reset is low.
`define ESV_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Check a property on every rising clock edge, also during reset.
`define ESV_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");

`endif

>>> sv/esv_pkg.sv
// -----------------------------------------------------------------------------
// esv_pkg
// Types, constants and codes shared by the strip energy sum blocks.
// -----------------------------------------------------------------------------
`default_nettype none

package esv_pkg;

	localparam int DETECTORS       = 4;
	localparam int STRIPS_PER_SIDE = 16;
	localparam int ADC_BITS        = 12;

	localparam int CHANNELS = DETECTORS * 2 * STRIPS_PER_SIDE;
	localparam int CH_W     = $clog2(CHANNELS);

	localparam int DET_W    = 2;
	localparam int STRIP_W  = 5;
	localparam int ADC_W    = 12;
	localparam int GAIN_W   = 18;
	localparam int OFFSET_W = 21;
	localparam int THR_W    = 19;
	localparam int LIMIT_W  = 22;
	localparam int ENABLE_W = 4;
	localparam int ENERGY_W = 22;
	localparam int SUM_W    = 26;
	localparam int COUNT_W  = 5;

	localparam int PROD_W = ADC_BITS + 1 + GAIN_W;
	localparam int E_W    = ((PROD_W - 8) > OFFSET_W ? (PROD_W - 8) : OFFSET_W) + 1;

	localparam int S_DATA_W   = 64;
	localparam int M_DATA_W   = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 22;

	localparam int QUEUE_DEPTH = 4;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [THR_W-1:0]    THRESHOLD_RESET = THR_W'(3932);
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET     = LIMIT_W'(524288);
	localparam logic [ENABLE_W-1:0] ENABLE_RESET    = ENABLE_W'(11);

	localparam logic [COUNT_W-1:0] VETO_COUNT = COUNT_W'(2);
	localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
	localparam logic [SUM_W-1:0]   SUM_MAX    = '1;
	localparam logic [SUM_W-1:0]   ENERGY_MAX = SUM_W'((2 ** ENERGY_W) - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD       = 2'd0,
		REG_UPPER_LIMIT     = 2'd1,
		REG_DETECTOR_ENABLE = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_LOAD   = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [THR_W-1:0]    threshold;
		logic [LIMIT_W-1:0]  upper_limit;
		logic [ENABLE_W-1:0] enable;
	} cfg_t;

	typedef struct packed {
		cmd_t                       cmd;
		logic [DET_W-1:0]           det;
		logic [CH_W-1:0]            addr;
		logic                       back_side;
		logic                       accum;
		logic                       enabled;
		logic                       last;
		logic [ADC_BITS-1:0]        adc;
		logic signed [GAIN_W-1:0]   gain;
		logic signed [OFFSET_W-1:0] offset;
	} entry_t;

endpackage

`default_nettype wire

>>> sv/esv_front.sv
// -----------------------------------------------------------------------------
// esv_front
// Unpacks incoming transfers, classifies them and forms queue entries.
// -----------------------------------------------------------------------------
`default_nettype none

module esv_front (
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [esv_pkg::S_DATA_W-1:0]  s_tdata,
	input  wire logic                          s_tuser,
	input  wire logic                          s_tlast,
	input  wire logic [esv_pkg::ENABLE_W-1:0]  enable,
	input  wire logic                          full,
	output logic                               push,
	output esv_pkg::entry_t                    entry
);

	logic [esv_pkg::DET_W-1:0]   det;
	logic [esv_pkg::STRIP_W-1:0] strip;
	logic [esv_pkg::ADC_W-1:0]   adc;
	logic                        det_ok;
	logic                        strip_ok;
	logic                        keep;

	always_comb begin
		det   = s_tdata[1:0];
		strip = s_tdata[6:2];
		adc   = s_tdata[18:7];

		det_ok   = 32'(det) < 32'(esv_pkg::DETECTORS);
		strip_ok = 32'(strip) < 32'(2 * esv_pkg::STRIPS_PER_SIDE);

		entry.cmd       = esv_pkg::cmd_t'(s_tuser);
		entry.det       = det;
		entry.addr      = esv_pkg::CH_W'(32'(det) * 32'(2 * esv_pkg::STRIPS_PER_SIDE)
			+ 32'(strip));
		entry.back_side = 32'(strip) >= 32'(esv_pkg::STRIPS_PER_SIDE);
		entry.enabled   = enable[det];
		entry.accum     = enable[det] && strip_ok;
		entry.last      = s_tlast;
		entry.adc       = esv_pkg::ADC_BITS'(adc);
		entry.gain      = $signed(s_tdata[36:19]);
		entry.offset    = $signed(s_tdata[57:37]);

		// drop what changes nothing downstream
		if (entry.cmd == esv_pkg::CMD_LOAD) begin
			keep = det_ok && strip_ok;
		end else begin
			keep = det_ok && (entry.accum || s_tlast);
		end

		s_tready = !full;
		push     = s_tvalid && s_tready && keep;
	end

endmodule

`default_nettype wire

>>> sv/esv_fifo.sv
// -----------------------------------------------------------------------------
// esv_fifo
// Short entry queue between the classify front and the calibrate back end.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module esv_fifo (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire esv_pkg::entry_t push_entry,
	input  wire logic         pop,
	output esv_pkg::entry_t   head,
	output logic              full,
	output logic              empty
);

	esv_pkg::entry_t                 slots_q [esv_pkg::QUEUE_DEPTH];
	logic [esv_pkg::Q_PTR_W-1:0]     wr_ptr_q;
	logic [esv_pkg::Q_PTR_W-1:0]     rd_ptr_q;
	logic [esv_pkg::Q_CNT_W-1:0]     count_q;

	function automatic logic [esv_pkg::Q_PTR_W-1:0] next_ptr(
		input logic [esv_pkg::Q_PTR_W-1:0] p
	);
		if (32'(p) == esv_pkg::QUEUE_DEPTH - 1) begin
			return '0;
		end
		return p + esv_pkg::Q_PTR_W'(1);
	endfunction

	assign full  = count_q == esv_pkg::Q_CNT_W'(esv_pkg::QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + esv_pkg::Q_CNT_W'(1);
				2'b01:   count_q <= count_q - esv_pkg::Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ESV_ASSERT(a_no_overflow, clk, arst_n, push |-> !full)
	`ESV_ASSERT(a_no_underflow, clk, arst_n, pop |-> !empty)

endmodule

`default_nettype wire

>>> sv/esv_back.sv
// -----------------------------------------------------------------------------
// esv_back
// Calibrates samples, accumulates per detector and side, emits side energies.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module esv_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire esv_pkg::cfg_t                 cfg,
	input  wire esv_pkg::entry_t               head,
	input  wire logic                          empty,
	output logic                               pop,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [esv_pkg::M_DATA_W-1:0]       m_tdata
);

	localparam int DI_W = $clog2(esv_pkg::DETECTORS) > 0 ? $clog2(esv_pkg::DETECTORS) : 1;
	localparam int M_USED = esv_pkg::DET_W + 2 * esv_pkg::ENERGY_W
		+ 2 * esv_pkg::COUNT_W + 3;

	typedef struct packed {
		logic                      valid;
		logic [esv_pkg::DET_W-1:0] det;
		logic                      back_side;
		logic                      accum;
		logic                      enabled;
		logic                      last;
	} ctrl_t;

	logic signed [esv_pkg::GAIN_W-1:0]   gain_mem [esv_pkg::CHANNELS];
	logic signed [esv_pkg::OFFSET_W-1:0] offset_mem [esv_pkg::CHANNELS];

	logic                                adv;

	ctrl_t                               ctrl_s1;
	logic [esv_pkg::ADC_BITS-1:0]        adc_s1;
	logic signed [esv_pkg::GAIN_W-1:0]   gain_s1;
	logic signed [esv_pkg::OFFSET_W-1:0] offset_s1;

	ctrl_t                               ctrl_s2;
	logic signed [esv_pkg::PROD_W-1:0]   prod_s2;
	logic signed [esv_pkg::OFFSET_W-1:0] offset_s2;

	logic signed [esv_pkg::PROD_W-1:0]   prod_shift;
	logic signed [esv_pkg::E_W-1:0]      e_calc;
	logic signed [esv_pkg::E_W-1:0]      thr_ext;

	ctrl_t                               ctrl_s3;
	logic                                fire_s3;
	logic [esv_pkg::E_W-2:0]             e_s3;

	logic [esv_pkg::SUM_W-1:0]           front_sum_q [esv_pkg::DETECTORS];
	logic [esv_pkg::SUM_W-1:0]           back_sum_q [esv_pkg::DETECTORS];
	logic [esv_pkg::COUNT_W-1:0]         front_count_q [esv_pkg::DETECTORS];
	logic [esv_pkg::COUNT_W-1:0]         back_count_q [esv_pkg::DETECTORS];

	logic [DI_W-1:0]                     di;
	logic [esv_pkg::SUM_W:0]             f_wide;
	logic [esv_pkg::SUM_W:0]             b_wide;
	logic [esv_pkg::SUM_W-1:0]           f_next;
	logic [esv_pkg::SUM_W-1:0]           b_next;
	logic [esv_pkg::COUNT_W-1:0]         fc_next;
	logic [esv_pkg::COUNT_W-1:0]         bc_next;
	logic                                upd_f;
	logic                                upd_b;

	logic                                emit_s4;
	logic [esv_pkg::DET_W-1:0]           det_s4;
	logic                                enabled_s4;
	logic [esv_pkg::SUM_W-1:0]           fsum_s4;
	logic [esv_pkg::SUM_W-1:0]           bsum_s4;
	logic [esv_pkg::COUNT_W-1:0]         fcount_s4;
	logic [esv_pkg::COUNT_W-1:0]         bcount_s4;

	logic [esv_pkg::ENERGY_W-1:0]        fe;
	logic [esv_pkg::ENERGY_W-1:0]        be;
	logic                                fv;
	logic                                bv;

	logic                                m_valid_q;
	logic [esv_pkg::DET_W-1:0]           m_det_q;
	logic [esv_pkg::ENERGY_W-1:0]        m_fe_q;
	logic [esv_pkg::ENERGY_W-1:0]        m_be_q;
	logic [esv_pkg::COUNT_W-1:0]         m_fc_q;
	logic [esv_pkg::COUNT_W-1:0]         m_bc_q;
	logic                                m_fv_q;
	logic                                m_bv_q;
	logic                                m_pv_q;

	assign adv = !m_valid_q || m_tready;
	assign pop = !empty && adv;

	// calibration store and registered read
	always_ff @(posedge clk) begin
		if (pop && head.cmd == esv_pkg::CMD_LOAD) begin
			gain_mem[head.addr]   <= head.gain;
			offset_mem[head.addr] <= head.offset;
		end
		if (pop) begin
			gain_s1   <= gain_mem[head.addr];
			offset_s1 <= offset_mem[head.addr];
			adc_s1    <= head.adc;
		end
	end

	always_comb begin
		prod_shift = prod_s2 >>> 8;
		e_calc     = esv_pkg::E_W'(prod_shift) + esv_pkg::E_W'(offset_s2);
		thr_ext    = $signed({{(esv_pkg::E_W - esv_pkg::THR_W){1'b0}}, cfg.threshold});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2   <= $signed({1'b0, adc_s1}) * gain_s1;
			offset_s2 <= offset_s1;
			e_s3      <= e_calc[esv_pkg::E_W-2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			fire_s3 <= 1'b0;
		end else if (adv) begin
			ctrl_s1.valid     <= pop && head.cmd == esv_pkg::CMD_SAMPLE;
			ctrl_s1.det       <= head.det;
			ctrl_s1.back_side <= head.back_side;
			ctrl_s1.accum     <= head.accum;
			ctrl_s1.enabled   <= head.enabled;
			ctrl_s1.last      <= head.last;
			ctrl_s2           <= ctrl_s1;
			ctrl_s3           <= ctrl_s2;
			fire_s3           <= ctrl_s2.valid && ctrl_s2.accum && (e_calc > thr_ext);
		end
	end

	// accumulate
	always_comb begin
		di     = DI_W'(ctrl_s3.det);
		upd_f  = fire_s3 && !ctrl_s3.back_side;
		upd_b  = fire_s3 && ctrl_s3.back_side;
		f_wide = {1'b0, front_sum_q[di]} + (esv_pkg::SUM_W + 1)'(e_s3);
		b_wide = {1'b0, back_sum_q[di]} + (esv_pkg::SUM_W + 1)'(e_s3);
		f_next = front_sum_q[di];
		b_next = back_sum_q[di];
		fc_next = front_count_q[di];
		bc_next = back_count_q[di];
		if (upd_f) begin
			f_next = f_wide > {1'b0, esv_pkg::SUM_MAX} ? esv_pkg::SUM_MAX
				: f_wide[esv_pkg::SUM_W-1:0];
			if (fc_next != esv_pkg::COUNT_MAX) begin
				fc_next = fc_next + esv_pkg::COUNT_W'(1);
			end
		end
		if (upd_b) begin
			b_next = b_wide > {1'b0, esv_pkg::SUM_MAX} ? esv_pkg::SUM_MAX
				: b_wide[esv_pkg::SUM_W-1:0];
			if (bc_next != esv_pkg::COUNT_MAX) begin
				bc_next = bc_next + esv_pkg::COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < esv_pkg::DETECTORS; i++) begin
				front_sum_q[i]   <= '0;
				back_sum_q[i]    <= '0;
				front_count_q[i] <= '0;
				back_count_q[i]  <= '0;
			end
			emit_s4 <= 1'b0;
		end else if (adv) begin
			emit_s4 <= ctrl_s3.valid && ctrl_s3.last;
			if (ctrl_s3.valid) begin
				if (ctrl_s3.last) begin
					front_sum_q[di]   <= '0;
					back_sum_q[di]    <= '0;
					front_count_q[di] <= '0;
					back_count_q[di]  <= '0;
				end else begin
					front_sum_q[di]   <= f_next;
					back_sum_q[di]    <= b_next;
					front_count_q[di] <= fc_next;
					back_count_q[di]  <= bc_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s4     <= ctrl_s3.det;
			enabled_s4 <= ctrl_s3.enabled;
			fsum_s4    <= f_next;
			bsum_s4    <= b_next;
			fcount_s4  <= fc_next;
			bcount_s4  <= bc_next;
		end
	end

	// veto, saturate and window
	always_comb begin
		if (fcount_s4 >= esv_pkg::VETO_COUNT) begin
			fe = '0;
		end else if (fsum_s4 > esv_pkg::ENERGY_MAX) begin
			fe = '1;
		end else begin
			fe = fsum_s4[esv_pkg::ENERGY_W-1:0];
		end
		if (bcount_s4 >= esv_pkg::VETO_COUNT) begin
			be = '0;
		end else if (bsum_s4 > esv_pkg::ENERGY_MAX) begin
			be = '1;
		end else begin
			be = bsum_s4[esv_pkg::ENERGY_W-1:0];
		end
		fv = (fe > esv_pkg::ENERGY_W'(cfg.threshold)) && (fe < cfg.upper_limit);
		bv = (be > esv_pkg::ENERGY_W'(cfg.threshold)) && (be < cfg.upper_limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= emit_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit_s4) begin
			m_det_q <= det_s4;
			if (enabled_s4) begin
				m_fe_q <= fe;
				m_be_q <= be;
				m_fc_q <= fcount_s4;
				m_bc_q <= bcount_s4;
				m_fv_q <= fv;
				m_bv_q <= bv;
				m_pv_q <= fv && bv;
			end else begin
				m_fe_q <= '0;
				m_be_q <= '0;
				m_fc_q <= '0;
				m_bc_q <= '0;
				m_fv_q <= 1'b0;
				m_bv_q <= 1'b0;
				m_pv_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(esv_pkg::M_DATA_W - M_USED){1'b0}}, m_pv_q, m_bv_q, m_fv_q,
		m_bc_q, m_fc_q, m_be_q, m_fe_q, m_det_q};

	`ESV_ASSERT(a_clear_on_emit, clk, arst_n,
		(adv && ctrl_s3.valid && ctrl_s3.last) |=> (front_count_q[$past(di)] == '0))
	`ESV_ASSERT(a_veto_zero, clk, arst_n,
		(m_valid_q && m_fc_q >= esv_pkg::VETO_COUNT) |-> (m_fe_q == '0 && !m_fv_q))

endmodule

`default_nettype wire

>>> sv/strip_energy_sum_multiplicity_veto.sv
// -----------------------------------------------------------------------------
// strip_energy_sum_multiplicity_veto
// Strip calibration, per-side energy sum and multiplicity veto, top level.
// -----------------------------------------------------------------------------
// One strip sample or calibration load is taken per clock, sustained, as long
// as the result side keeps up; the input accepts whenever the four-entry queue
// between the classifier and the calibrate/accumulate pipeline has room. A
// result passes from the queue through the calibration read, multiply, energy
// and accumulate registers to the output register; each entry waiting ahead of
// it in the queue and each cycle the result side stalls delays it further.
// Per-detector accumulation closes in a single stage, so samples of the same
// detector may follow each other in consecutive cycles. The calibration tables
// need loading before use and have no clearing pass after reset.
`default_nettype none

module strip_energy_sum_multiplicity_veto (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// detector[1:0], strip[6:2], adc_value[18:7], gain_word[36:19],
	// offset_word[57:37], zero fill
	input  wire logic [esv_pkg::S_DATA_W-1:0]    s_tdata,
	// command
	input  wire logic                            s_tuser,
	input  wire logic                            s_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// detector_out[1:0], front_energy[23:2], back_energy[45:24],
	// front_fired[50:46], back_fired[55:51], front_valid[56], back_valid[57],
	// pair_valid[58], zero fill
	output logic [esv_pkg::M_DATA_W-1:0]         m_tdata,
	input  wire logic                            cfg_we,
	input  wire logic [esv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [esv_pkg::CFG_DATA_W-1:0]  cfg_data
);

	esv_pkg::cfg_t    cfg_q;
	esv_pkg::entry_t  push_entry;
	esv_pkg::entry_t  head;
	logic             push;
	logic             pop;
	logic             full;
	logic             empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold   <= esv_pkg::THRESHOLD_RESET;
			cfg_q.upper_limit <= esv_pkg::LIMIT_RESET;
			cfg_q.enable      <= esv_pkg::ENABLE_RESET;
		end else if (cfg_we) begin
			unique case (esv_pkg::cfg_reg_t'(cfg_index))
				esv_pkg::REG_THRESHOLD:       cfg_q.threshold   <= cfg_data[esv_pkg::THR_W-1:0];
				esv_pkg::REG_UPPER_LIMIT:     cfg_q.upper_limit <= cfg_data[esv_pkg::LIMIT_W-1:0];
				esv_pkg::REG_DETECTOR_ENABLE: cfg_q.enable      <= cfg_data[esv_pkg::ENABLE_W-1:0];
				default: ;
			endcase
		end
	end

	esv_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.enable   (cfg_q.enable),
		.full     (full),
		.push     (push),
		.entry    (push_entry)
	);

	esv_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (full),
		.empty      (empty)
	);

	esv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

>>> sim/strip_energy_check_pkg.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// strip_energy_check_pkg
// Item types and the event energy checker for the strip energy sum testbench.
// The checker keeps its own calibration tables, side sums and strip counts,
// predicts each detector's energies when a last-flagged sample is accepted
// and compares every result transfer with the oldest prediction.
// -----------------------------------------------------------------------------
package strip_energy_check_pkg;

	import esv_pkg::*;

	typedef struct {
		cmd_t                       command;
		logic [DET_W-1:0]           detector;
		logic [STRIP_W-1:0]         strip;
		logic [ADC_W-1:0]           adc_value;
		logic signed [GAIN_W-1:0]   gain_word;
		logic signed [OFFSET_W-1:0] offset_word;
		logic                       last_strip;
	} strip_item_t;

	typedef struct {
		logic [DET_W-1:0]    detector;
		logic [ENERGY_W-1:0] front_energy;
		logic [ENERGY_W-1:0] back_energy;
		logic [COUNT_W-1:0]  front_fired;
		logic [COUNT_W-1:0]  back_fired;
		logic                front_valid;
		logic                back_valid;
		logic                pair_valid;
	} detector_energies_t;

	class event_energy_checker;
		logic [THR_W-1:0]           threshold;
		logic [LIMIT_W-1:0]         upper_limit;
		logic [ENABLE_W-1:0]        enable;
		logic signed [GAIN_W-1:0]   gain_tab [CHANNELS];
		logic signed [OFFSET_W-1:0] offset_tab [CHANNELS];
		longint                     front_sum [DETECTORS];
		longint                     back_sum [DETECTORS];
		int unsigned                front_cnt [DETECTORS];
		int unsigned                back_cnt [DETECTORS];
		detector_energies_t         pending_energies [$];
		int unsigned                mismatches;

		function new();
			threshold = THRESHOLD_RESET;
			upper_limit = LIMIT_RESET;
			enable = ENABLE_RESET;
			mismatches = 0;
			for (int i = 0; i < CHANNELS; i++) begin
				gain_tab[i] = '0;
				offset_tab[i] = '0;
			end
			for (int d = 0; d < DETECTORS; d++) begin
				front_sum[d] = 0;
				back_sum[d] = 0;
				front_cnt[d] = 0;
				back_cnt[d] = 0;
			end
		endfunction

		function void set_config(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
			REG_THRESHOLD: threshold = value[THR_W-1:0];
			REG_UPPER_LIMIT: upper_limit = value[LIMIT_W-1:0];
			REG_DETECTOR_ENABLE: enable = value[ENABLE_W-1:0];
			default: ;
			endcase
		endfunction

		function int unsigned outstanding();
			return pending_energies.size();
		endfunction

		function longint vetoed_energy(longint sum, int unsigned cnt);
			if (cnt >= VETO_COUNT)
				return 0;
			return (sum > longint'(ENERGY_MAX)) ? longint'(ENERGY_MAX) : sum;
		endfunction

		function logic in_window(longint e);
			return (e > longint'(threshold)) && (e < longint'(upper_limit));
		endfunction

		function void take_item(strip_item_t it);
			int unsigned        ch;
			int unsigned        d;
			longint             e;
			longint             fe;
			longint             be;
			logic               on;
			detector_energies_t r;
			d = it.detector;
			ch = d * 2 * STRIPS_PER_SIDE + int'(it.strip);
			if (it.command == CMD_LOAD) begin
				if (int'(it.strip) < 2 * STRIPS_PER_SIDE) begin
					gain_tab[ch] = it.gain_word;
					offset_tab[ch] = it.offset_word;
				end
				return;
			end
			on = enable[d];
			if (on && int'(it.strip) < 2 * STRIPS_PER_SIDE) begin
				e = ((longint'(it.adc_value) * longint'(gain_tab[ch])) >>> 8)
					+ longint'(offset_tab[ch]);
				if (e > longint'(threshold)) begin
					if (int'(it.strip) < STRIPS_PER_SIDE) begin
						front_sum[d] = front_sum[d] + e;
						if (front_sum[d] > longint'(SUM_MAX))
							front_sum[d] = longint'(SUM_MAX);
						if (front_cnt[d] < COUNT_MAX)
							front_cnt[d]++;
					end else begin
						back_sum[d] = back_sum[d] + e;
						if (back_sum[d] > longint'(SUM_MAX))
							back_sum[d] = longint'(SUM_MAX);
						if (back_cnt[d] < COUNT_MAX)
							back_cnt[d]++;
					end
				end
			end
			if (!it.last_strip)
				return;
			r = '{default: '0};
			r.detector = it.detector;
			if (on) begin
				fe = vetoed_energy(front_sum[d], front_cnt[d]);
				be = vetoed_energy(back_sum[d], back_cnt[d]);
				r.front_energy = ENERGY_W'(fe);
				r.back_energy = ENERGY_W'(be);
				r.front_fired = COUNT_W'(front_cnt[d]);
				r.back_fired = COUNT_W'(back_cnt[d]);
				r.front_valid = in_window(fe);
				r.back_valid = in_window(be);
				r.pair_valid = r.front_valid & r.back_valid;
			end
			front_sum[d] = 0;
			back_sum[d] = 0;
			front_cnt[d] = 0;
			back_cnt[d] = 0;
			pending_energies.push_back(r);
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 50)
				$display("error: %s", msg);
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want,
			logic [DET_W-1:0] det);
			if (got !== want)
				report($sformatf("detector %0d %s: got %0d, expected %0d",
					det, name, got, want));
		endtask

		task check_energies(logic [M_DATA_W-1:0] d);
			detector_energies_t want;
			if (pending_energies.size() == 0) begin
				report($sformatf("result for detector %0d with none outstanding", d[1:0]));
				return;
			end
			want = pending_energies.pop_front();
			compare_field("detector_out", d[1:0], want.detector, want.detector);
			compare_field("front_energy", d[23:2], want.front_energy, want.detector);
			compare_field("back_energy", d[45:24], want.back_energy, want.detector);
			compare_field("front_fired", d[50:46], want.front_fired, want.detector);
			compare_field("back_fired", d[55:51], want.back_fired, want.detector);
			compare_field("front_valid", d[56], want.front_valid, want.detector);
			compare_field("back_valid", d[57], want.back_valid, want.detector);
			compare_field("pair_valid", d[58], want.pair_valid, want.detector);
		endtask
	endclass

endpackage

>>> sim/tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb
// Testbench for strip_energy_sum_multiplicity_veto.
// Fills the calibration tables, runs a directed set of events (window edges,
// multiplicity veto, negative energies, disabled detector, loads carrying a
// last flag), then random events under several register settings, with
// random gaps on the sample stream and random stalls on the result stream.
// -----------------------------------------------------------------------------
module tb;

	import esv_pkg::*;
	import strip_energy_check_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int RANDOM_ITEMS   = 360;
	localparam int PHASES         = 6;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic                  s_tuser;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	event_energy_checker energies;

	int unsigned items_sent = 0;
	int unsigned tx_burst_left = 0;
	int unsigned rx_mode = 0;
	int unsigned rx_mode_left = 0;
	int unsigned rx_stall_left = 0;
	int unsigned idle_cycles = 0;

	strip_energy_sum_multiplicity_veto u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (tx_burst_left != 0) begin
			tx_burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			tx_burst_left = $urandom_range(20, 100);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int rand_gain();
		if ($urandom_range(0, 3) == 0)
			return int'($urandom);
		return int'($urandom_range(0, 2047));
	endfunction

	function automatic int rand_offset();
		if ($urandom_range(0, 3) == 0)
			return int'($urandom);
		return int'($urandom_range(0, 8191)) - 4096;
	endfunction

	function automatic int rand_adc();
		if ($urandom_range(0, 7) == 0)
			return ($urandom_range(0, 1) != 0) ? 4095 : 0;
		return int'($urandom_range(0, 4095));
	endfunction

	task automatic send_item(input strip_item_t it);
		int unsigned gap;
		s_tdata <= S_DATA_W'({it.offset_word, it.gain_word, it.adc_value, it.strip,
			it.detector});
		s_tuser <= it.command;
		s_tlast <= it.last_strip;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		energies.take_item(it);
		items_sent++;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_load(input int det, input int strip, input int gain,
		input int offset, input bit last);
		strip_item_t it;
		it.command = CMD_LOAD;
		it.detector = DET_W'(det);
		it.strip = STRIP_W'(strip);
		it.adc_value = ADC_W'($urandom);
		it.gain_word = GAIN_W'(gain);
		it.offset_word = OFFSET_W'(offset);
		it.last_strip = last;
		send_item(it);
	endtask

	task automatic send_sample(input int det, input int strip, input int adc, input bit last);
		strip_item_t it;
		it.command = CMD_SAMPLE;
		it.detector = DET_W'(det);
		it.strip = STRIP_W'(strip);
		it.adc_value = ADC_W'(adc);
		it.gain_word = GAIN_W'($urandom);
		it.offset_word = OFFSET_W'($urandom);
		it.last_strip = last;
		send_item(it);
	endtask

	// hold the sample stream until every result is in and the pipeline is empty
	task automatic drain();
		s_tvalid <= 1'b0;
		while (energies.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		energies.set_config(idx, CFG_DATA_W'(value));
	endtask

	task automatic set_regs(input int unsigned thr, input int unsigned lim,
		input int unsigned en);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_UPPER_LIMIT, lim);
		write_reg(REG_DETECTOR_ENABLE, en);
		cfg_we <= 1'b0;
	endtask

	task automatic random_event();
		int unsigned r;
		int unsigned det;
		int unsigned n;
		int unsigned strip;
		int unsigned back_bias;
		r = $urandom_range(0, 99);
		det = $urandom_range(0, DETECTORS - 1);
		if (r < 8) begin
			send_load(det, $urandom_range(0, 2 * STRIPS_PER_SIDE - 1), rand_gain(),
				rand_offset(), $urandom_range(0, 1));
		end else if (r < 10) begin
			// drive the strip count and the side sum toward saturation on one strip
			strip = $urandom_range(0, 2 * STRIPS_PER_SIDE - 1);
			send_load(det, strip, 131071, 1048575, 1'b0);
			n = $urandom_range(24, 40);
			for (int i = 0; i < n; i++)
				send_sample(det, strip, $urandom_range(3000, 4095), i == n - 1);
		end else if (r < 16) begin
			send_sample(det, $urandom_range(0, 2 * STRIPS_PER_SIDE - 1), rand_adc(),
				$urandom_range(0, 1));
		end else begin
			n = $urandom_range(1, 5);
			back_bias = $urandom_range(0, 2);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 1) != 0)
					strip = STRIPS_PER_SIDE * (back_bias == 0 ? 0 : 1)
						+ $urandom_range(0, STRIPS_PER_SIDE - 1);
				else
					strip = $urandom_range(0, 2 * STRIPS_PER_SIDE - 1);
				send_sample(det, strip, rand_adc(), i == n - 1);
			end
		end
		if ($urandom_range(0, 39) == 0)
			drain();
	endtask

	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(16, 256);
		end else begin
			rx_mode_left--;
		end
		if (rx_stall_left != 0) begin
			rx_stall_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: begin
				if ($urandom_range(0, 15) == 0)
					rx_stall_left = $urandom_range(8, 40);
				m_tready <= ($urandom_range(0, 1) != 0);
			end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			energies.check_energies(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int unsigned phase_end;
		energies = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		s_tlast <= 1'b0;
		m_tready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_THRESHOLD;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ch = 0; ch < CHANNELS; ch++)
			send_load(ch / (2 * STRIPS_PER_SIDE), ch % (2 * STRIPS_PER_SIDE),
				$urandom_range(0, 2047), int'($urandom_range(0, 8191)) - 4096,
				$urandom_range(0, 1));

		send_load(3, 2, 256, 0, 1'b0);
		send_load(3, 18, 256, 0, 1'b1);
		send_sample(3, 2, 3933, 1'b0);
		send_sample(3, 18, 3932, 1'b1);
		send_sample(3, 2, 4000, 1'b0);
		send_sample(3, 2, 4000, 1'b0);
		send_sample(3, 18, 4095, 1'b1);
		send_sample(3, 2, 5000, 1'b0);
		send_sample(3, 18, 6000, 1'b1);
		send_load(1, 5, 131071, 1048575, 1'b0);
		send_sample(1, 5, 4095, 1'b1);
		send_load(0, 31, -131072, -1048576, 1'b1);
		send_sample(0, 31, 4095, 1'b0);
		send_sample(0, 31, 0, 1'b1);
		send_sample(2, 0, 4095, 1'b1);
		send_sample(0, 0, 0, 1'b0);
		send_sample(0, 15, 4095, 1'b1);
		send_sample(1, 16, 0, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
			0: set_regs(0, 4194303, 15);
			1: set_regs(524287, 0, 0);
			2: set_regs($urandom_range(0, 8000), $urandom_range(4000, 600000),
				$urandom_range(0, 15));
			3: set_regs(THRESHOLD_RESET, LIMIT_RESET, ENABLE_RESET);
			4: set_regs($urandom_range(0, 524287), $urandom_range(0, 4194303),
				$urandom_range(0, 15));
			default: set_regs(1, 4194302, 15);
			endcase
			phase_end = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < phase_end)
				random_event();
		end

		drain();
		if (energies.mismatches == 0 && energies.outstanding() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
